@@ rtl/deq_pkg.sv @@
// Package for the double-ended queue: transaction structs, command and status codes.
// No dependencies; imported by deq_ctrl and double_ended_queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEQ_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic [STATUS_W-1:0]       status;
    } t_deq_out;

    // Per-transaction info handed from the control unit to the output stage
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
        logic                rev;
        logic                fwd_lo;
        logic                fwd_hi;
    } t_deq_meta;

endpackage

`default_nettype wire

@@ rtl/deq_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_a,
    output logic      [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

@@ rtl/deq_ctrl.sv @@
// Deque control: head index, count, reversed flag; next-state, store write and read slots.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
    parameter int  CAPACITY = deq_pkg::DEQ_CAPACITY,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire deq_pkg::t_deq_in  i_item,
    output deq_pkg::t_deq_meta     o_meta,
    output logic                   o_wr_en,
    output logic [IDX_W-1:0]       o_wr_addr,
    output logic [IDX_W-1:0]       o_lo_addr,
    output logic [IDX_W-1:0]       o_hi_addr
);

    import deq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W + 1)'(CAPACITY);

    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    n_head;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_rev;
    logic                n_rev;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_head_dec;
    logic [IDX_W-1:0]    w_head_inc;
    logic [IDX_W-1:0]    w_tail_slot;
    logic [IDX_W-1:0]    w_end_slot;
    logic                w_wr;
    logic                w_at_start;
    logic [CNT_W+4:0]    w_cnt_ext;

    function automatic logic [IDX_W-1:0] wrap_sum(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
        if (s >= CAP_SUM) begin
            s = s - CAP_SUM;
        end
        return s[IDX_W-1:0];
    endfunction

    assign w_head_dec  = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign w_head_inc  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_tail_slot = wrap_sum(r_head, r_cnt);

    always_comb begin
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_rev      = r_rev;
        w_status   = ST_DONE;
        w_wr       = 1'b0;
        w_at_start = 1'b0;
        o_wr_addr  = w_tail_slot;
        case (i_item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                w_at_start = (i_item.command == CMD_PUSH_FRONT) ^ r_rev;
                if (r_cnt == CAP_CNT) begin
                    w_status = ST_PUSH_FULL;
                end else begin
                    w_wr  = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (w_at_start) begin
                        n_head    = w_head_dec;
                        o_wr_addr = w_head_dec;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                w_at_start = (i_item.command == CMD_POP_FRONT) ^ r_rev;
                if (r_cnt == '0) begin
                    w_status = ST_POP_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (w_at_start) begin
                        n_head = w_head_inc;
                    end
                end
            end
            CMD_REVERSE: begin
                if (r_cnt >= CNT_W'(2)) begin
                    n_rev = ~r_rev;
                end
            end
            CMD_CLEAR: begin
                n_head = '0;
                n_cnt  = '0;
                n_rev  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Physical end slot after the step; only meaningful when not empty
    assign w_end_slot = wrap_sum(n_head, n_cnt);
    assign o_lo_addr  = n_head;
    assign o_hi_addr  = (w_end_slot == '0) ? LAST_IDX : w_end_slot - 1'b1;
    assign o_wr_en    = i_step && w_wr;
    assign w_cnt_ext  = {5'b0, n_cnt};

    always_comb begin
        o_meta.count    = w_cnt_ext[COUNT_W-1:0];
        o_meta.is_empty = (n_cnt == '0);
        o_meta.status   = w_status;
        o_meta.rev      = n_rev;
        o_meta.fwd_lo   = w_wr && (o_wr_addr == o_lo_addr);
        o_meta.fwd_hi   = w_wr && (o_wr_addr == o_hi_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
            r_rev  <= 1'b0;
        end else if (i_step) begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
            r_rev  <= n_rev;
        end
    end

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue: input register, control, store, result stage.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
//   Channel   Valid         Stall         Payload                  Direction
//   command   i_in_valid    o_in_stall    i_in_data  (t_deq_in)    in
//   result    o_out_valid   i_out_stall   o_out_data (t_deq_out)   out
//
// One transaction per cycle sustained while the result is not stalled; an accepted command
// passes from the input register to the result register, from which the result is taken.
// The command is applied to head/count/flag and the store as it leaves the input
// register; the store's registered read ports supply both end words to the result stage.
// Reset clears control state only; store contents never reach the output before being written.
// A stalled result holds the result stage, and the input register stalls behind it.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire deq_pkg::t_deq_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output deq_pkg::t_deq_out      o_out_data
);

    import deq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                r_in_valid;
    t_deq_in             r_in;
    logic                r_out_valid;
    t_deq_meta           r_meta;
    logic [VALUE_W-1:0]  r_word;
    logic                w_adv;
    logic                w_step;
    t_deq_meta           w_meta;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [IDX_W-1:0]    w_lo_addr;
    logic [IDX_W-1:0]    w_hi_addr;
    logic [VALUE_W-1:0]  w_rd_lo;
    logic [VALUE_W-1:0]  w_rd_hi;
    logic [VALUE_W-1:0]  w_lo_word;
    logic [VALUE_W-1:0]  w_hi_word;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_step     = w_adv && r_in_valid;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    deq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_item    (r_in),
        .o_meta    (w_meta),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_lo_addr (w_lo_addr),
        .o_hi_addr (w_hi_addr)
    );

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (r_in.value),
        .i_rd_en     (w_adv),
        .i_rd_addr_a (w_lo_addr),
        .i_rd_addr_b (w_hi_addr),
        .o_rd_data_a (w_rd_lo),
        .o_rd_data_b (w_rd_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv) begin
            r_meta <= w_meta;
            r_word <= r_in.value;
        end
    end

    // Word pushed this transaction bypasses the store read
    assign w_lo_word = r_meta.fwd_lo ? r_word : w_rd_lo;
    assign w_hi_word = r_meta.fwd_hi ? r_word : w_rd_hi;

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_data.count    = r_meta.count;
        o_out_data.is_empty = r_meta.is_empty;
        o_out_data.status   = r_meta.status;
        if (r_meta.is_empty) begin
            o_out_data.front_value = '0;
            o_out_data.back_value  = '0;
        end else if (r_meta.rev) begin
            o_out_data.front_value = w_hi_word;
            o_out_data.back_value  = w_lo_word;
        end else begin
            o_out_data.front_value = w_lo_word;
            o_out_data.back_value  = w_hi_word;
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.command == CMD_CLEAR) |=> (r_out_valid && r_meta.is_empty))
        else $error("clear transaction did not yield an empty result");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_meta.status == ST_POP_EMPTY) |-> r_meta.is_empty)
        else $error("ignored pop reported a non-empty deque");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_meta.status == ST_PUSH_FULL) |-> !r_meta.is_empty)
        else $error("rejected push reported an empty deque");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
